@@ rtl/tgr_pkg.sv @@
package tgr_pkg;

	localparam int GLYPH_W    = 5;
	localparam int GLYPH_H    = 7;
	localparam int GLYPH_DOTS = GLYPH_W * GLYPH_H;
	localparam int GLYPH_CNT  = 95;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// exact floor(x/7) as (x*2341)>>14 for x below 5466
	localparam logic [11:0] DIV7_MUL = 12'd2341;
	// exact floor(3*fs/5) as (fs*615)>>10 for fs below 342
	localparam logic [9:0]  ADV_MUL  = 10'd615;

	localparam logic [6:0] CHAR_NEWLINE = 7'd10;
	localparam logic [6:0] CHAR_FIRST   = 7'd32;
	localparam logic [6:0] CHAR_LAST    = 7'd126;

	localparam logic [11:0] ORIGIN_X_RST  = 12'd0;
	localparam logic [11:0] ORIGIN_Y_RST  = 12'd0;
	localparam logic [7:0]  FONT_SIZE_RST = 8'd14;
	localparam logic [31:0] COLOR_RST     = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REG_ORIGIN_X  = 2'd0,
		REG_ORIGIN_Y  = 2'd1,
		REG_FONT_SIZE = 2'd2,
		REG_COLOR     = 2'd3
	} cfg_reg_t;

	// settings the dot emitter needs; offsets and block are derived from the font size at write time
	typedef struct packed {
		logic [GLYPH_W-1:0][7:0] off_x;
		logic [GLYPH_H-1:0][7:0] off_y;
		logic [5:0]              block;
		logic [31:0]             color;
	} tgr_cfg_t;

	// column bytes packed column 0 in the low byte; bit r of a byte is row r
	localparam logic [39:0] GLYPH_ROM [0:GLYPH_CNT-1] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h122A7F2A24,
		40'h6264081323, 40'h5022554936, 40'h0000030500, 40'h0041221C00, 40'h001C224100,
		40'h082A1C2A08, 40'h08083E0808, 40'h0000305000, 40'h0808080808, 40'h0000606000,
		40'h0204081020, 40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
		40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101, 40'h3649494936,
		40'h1E29494906, 40'h0000363600, 40'h0000365600, 40'h4122140800, 40'h1414141414,
		40'h0008142241, 40'h0609510102, 40'h3E41794932, 40'h7E1111117E, 40'h364949497F,
		40'h224141413E, 40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
		40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
		40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
		40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
		40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040, 40'h0004020100,
		40'h7854545420, 40'h384444487F, 40'h2044444438, 40'h7F48444438, 40'h1854545438,
		40'h0201097E08, 40'h3C54541408, 40'h780404087F, 40'h00407D4400, 40'h003D444020,
		40'h4428107F00, 40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
		40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448, 40'h2040443F04,
		40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h3C5050500C,
		40'h444C546444, 40'h0041360800, 40'h00007F0000, 40'h0008364100, 40'h081C2A0808
	};

	// row-major dot mask: bit r*GLYPH_W+c is row r, column c
	function automatic logic [GLYPH_DOTS-1:0] glyph_mask(input logic [6:0] idx);
		logic [39:0]            cols;
		logic [GLYPH_DOTS-1:0]  m;
		cols = GLYPH_ROM[idx];
		for (int r = 0; r < GLYPH_H; r++) begin
			for (int c = 0; c < GLYPH_W; c++) begin
				m[r*GLYPH_W + c] = cols[c*8 + r];
			end
		end
		return m;
	endfunction

	// floor(k*fs/7)
	function automatic logic [7:0] dot_offset(input logic [7:0] fs, input logic [2:0] k);
		logic [24:0] p;
		p = 25'(k) * 25'(fs) * 25'(DIV7_MUL);
		return p[21:14];
	endfunction

	// max(1, (fs+3)/7)
	function automatic logic [5:0] block_of(input logic [7:0] fs);
		logic [20:0] p;
		p = 21'(9'(fs) + 9'd3) * 21'(DIV7_MUL);
		return (p[19:14] == 6'd0) ? 6'd1 : p[19:14];
	endfunction

	// floor(3*fs/5)
	function automatic logic [7:0] advance_of(input logic [7:0] fs);
		logic [17:0] p;
		p = 18'(fs) * 18'(ADV_MUL);
		return p[17:10];
	endfunction

endpackage

@@ rtl/text_glyph_dot_rasterizer.sv @@
// 5x7 character generator: turns a stream of text words into one word per lit dot.
// Input stream: s_axis_tdata[6:0] is the character code, s_axis_tuser = 1 starts
// new text at the origin (code ignored). Newline (10) returns the pen to origin_x
// and steps it down by font_size. Codes 32..126 are drawn; other codes are dropped.
// Output stream: one word per lit dot in row-major order, tlast on the glyph's last
// dot. Control items and the space glyph produce no output.
// Config: cfg_we with cfg_index 0 origin_x, 1 origin_y, 2 font_size, 3 text_color.
// Write only while the block is idle; offsets and block size are derived at write.
// Path: with the queue empty and the emitter idle, an accepted character is written
// to the queue, popped into the emitter, then its first dot goes to the output register.
// Throughput: one dot word per cycle from the dot emitter while the receiver is
// ready; a glyph has up to 35 lit dots, and a blank glyph is popped with no output.
// The front takes one word per cycle while the 4-entry glyph queue has room, so
// control words and pen updates run ahead of the dots being emitted.
// A stalled receiver holds the output register; the emitter waits, the queue fills
// and then s_axis_tready drops. Reset clears pen, queue and output valid and loads
// the register defaults (font size 14, white).
module text_glyph_dot_rasterizer #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [6:0] char_code, [7] zero
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [15:0] dot_x, [31:16] dot_y, [37:32] block_size,
	                                    // [69:38] color, [71:70] zero
	output logic        m_axis_tlast    // last
);

	localparam int QW = 7 + 2 * COORD_BITS;

	tgr_pkg::tgr_cfg_t     cfg;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	logic [6:0]            push_glyph;
	logic [COORD_BITS-1:0] push_pen_x;
	logic [COORD_BITS-1:0] push_pen_y;
	logic [QW-1:0]         pop_data;

	tgr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_glyph       (push_glyph),
		.q_pen_x       (push_pen_x),
		.q_pen_y       (push_pen_y),
		.cfg           (cfg)
	);

	tgr_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_glyph, push_pen_x, push_pen_y}),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	tgr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (!q_empty),
		.q_glyph       (pop_data[QW-1 -: 7]),
		.q_pen_x       (pop_data[2*COORD_BITS-1 -: COORD_BITS]),
		.q_pen_y       (pop_data[COORD_BITS-1:0]),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ rtl/tgr_queue.sv @@
module tgr_queue #(
	parameter int WIDTH = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]            mem_q [tgr_pkg::QUEUE_DEPTH];
	logic [tgr_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [tgr_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [tgr_pkg::QUEUE_AW:0]   cnt_q;

	assign full     = (cnt_q == (tgr_pkg::QUEUE_AW+1)'(tgr_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (tgr_pkg::QUEUE_AW+1)'(tgr_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

@@ rtl/tgr_front.sv @@
module tgr_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [6:0]            q_glyph,
	output logic [COORD_BITS-1:0] q_pen_x,
	output logic [COORD_BITS-1:0] q_pen_y,
	output tgr_pkg::tgr_cfg_t     cfg
);

	logic [11:0]           origin_x_q;
	logic [11:0]           origin_y_q;
	logic [7:0]            font_size_q;
	logic [7:0]            adv_q;
	tgr_pkg::tgr_cfg_t     cfg_q;
	logic [COORD_BITS-1:0] pen_x_q;
	logic [COORD_BITS-1:0] pen_y_q;

	logic       accept;
	logic [6:0] code;
	logic       printable;
	logic       newline;

	assign code      = s_axis_tdata[6:0];
	assign printable = (code >= tgr_pkg::CHAR_FIRST) && (code <= tgr_pkg::CHAR_LAST);
	assign newline   = (code == tgr_pkg::CHAR_NEWLINE);

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = accept && !s_axis_tuser && printable;
	assign q_glyph       = code - tgr_pkg::CHAR_FIRST;
	assign q_pen_x       = pen_x_q;
	assign q_pen_y       = pen_y_q;
	assign cfg           = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= tgr_pkg::ORIGIN_X_RST;
			origin_y_q   <= tgr_pkg::ORIGIN_Y_RST;
			font_size_q  <= tgr_pkg::FONT_SIZE_RST;
			adv_q        <= tgr_pkg::advance_of(tgr_pkg::FONT_SIZE_RST);
			cfg_q.block  <= tgr_pkg::block_of(tgr_pkg::FONT_SIZE_RST);
			cfg_q.color  <= tgr_pkg::COLOR_RST;
			for (int k = 0; k < tgr_pkg::GLYPH_W; k++) begin
				cfg_q.off_x[k] <= tgr_pkg::dot_offset(tgr_pkg::FONT_SIZE_RST, 3'(k));
			end
			for (int k = 0; k < tgr_pkg::GLYPH_H; k++) begin
				cfg_q.off_y[k] <= tgr_pkg::dot_offset(tgr_pkg::FONT_SIZE_RST, 3'(k));
			end
		end else if (cfg_we) begin
			case (tgr_pkg::cfg_reg_t'(cfg_index))
				tgr_pkg::REG_ORIGIN_X: origin_x_q <= cfg_wdata[11:0];
				tgr_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_wdata[11:0];
				tgr_pkg::REG_FONT_SIZE: begin
					font_size_q <= cfg_wdata[7:0];
					adv_q       <= tgr_pkg::advance_of(cfg_wdata[7:0]);
					cfg_q.block <= tgr_pkg::block_of(cfg_wdata[7:0]);
					for (int k = 0; k < tgr_pkg::GLYPH_W; k++) begin
						cfg_q.off_x[k] <= tgr_pkg::dot_offset(cfg_wdata[7:0], 3'(k));
					end
					for (int k = 0; k < tgr_pkg::GLYPH_H; k++) begin
						cfg_q.off_y[k] <= tgr_pkg::dot_offset(cfg_wdata[7:0], 3'(k));
					end
				end
				tgr_pkg::REG_COLOR: cfg_q.color <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pen moves at accept; glyph jobs carry the pen they start from
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (accept) begin
			if (s_axis_tuser) begin
				pen_x_q <= COORD_BITS'(origin_x_q);
				pen_y_q <= COORD_BITS'(origin_y_q);
			end else if (newline) begin
				pen_x_q <= COORD_BITS'(origin_x_q);
				pen_y_q <= pen_y_q + COORD_BITS'(font_size_q);
			end else if (printable) begin
				pen_x_q <= pen_x_q + COORD_BITS'(adv_q);
			end
		end
	end

endmodule

@@ rtl/tgr_back.sv @@
module tgr_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tgr_pkg::tgr_cfg_t     cfg,
	input  logic                  q_valid,
	input  logic [6:0]            q_glyph,
	input  logic [COORD_BITS-1:0] q_pen_x,
	input  logic [COORD_BITS-1:0] q_pen_y,
	output logic                  q_pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [71:0]           m_axis_tdata,
	output logic                  m_axis_tlast
);

	logic                           active_q;
	logic [tgr_pkg::GLYPH_DOTS-1:0] mask_q;
	logic [COORD_BITS-1:0]          pen_x_q;
	logic [COORD_BITS-1:0]          pen_y_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] dot_x_q;
	logic [COORD_BITS-1:0] dot_y_q;
	logic [5:0]            block_q;
	logic [31:0]           color_q;
	logic                  last_q;

	logic [tgr_pkg::GLYPH_DOTS-1:0] mask_rest;
	logic [tgr_pkg::GLYPH_DOTS-1:0] new_mask;
	logic                           last_dot;
	logic                           emit;
	logic [2:0]                     sel_r;
	logic [2:0]                     sel_c;

	// clear lowest lit dot
	assign mask_rest = mask_q & (mask_q - 1'b1);
	assign last_dot  = (mask_rest == '0);
	assign emit      = active_q && (!out_valid_q || m_axis_tready);
	assign q_pop     = q_valid && (!active_q || (emit && last_dot));
	assign new_mask  = tgr_pkg::glyph_mask(q_glyph);

	// lowest lit dot in row-major order
	always_comb begin
		sel_r = '0;
		sel_c = '0;
		for (int r = tgr_pkg::GLYPH_H - 1; r >= 0; r--) begin
			for (int c = tgr_pkg::GLYPH_W - 1; c >= 0; c--) begin
				if (mask_q[r*tgr_pkg::GLYPH_W + c]) begin
					sel_r = 3'(r);
					sel_c = 3'(c);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			active_q <= (new_mask != '0);
		end else if (emit && last_dot) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mask_q  <= new_mask;
			pen_x_q <= q_pen_x;
			pen_y_q <= q_pen_y;
		end else if (emit) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dot_x_q <= pen_x_q + COORD_BITS'(cfg.off_x[sel_c]);
			dot_y_q <= pen_y_q + COORD_BITS'(cfg.off_y[sel_r]);
			block_q <= cfg.block;
			color_q <= cfg.color;
			last_q  <= last_dot;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {2'b00, color_q, block_q, 16'(dot_y_q), 16'(dot_x_q)};

	a_active_has_dots: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (mask_q != '0))
		else $error("active glyph with no dots left");

	a_last_ends_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_dot && !q_valid) |=> !active_q)
		else $error("glyph still active after its last dot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output word changed while stalled");

endmodule
